// ----- design/pidc_pkg.sv -----
// pidc_pkg: shared types and constants for the clamped PID controller.
// No dependencies; imported by pid_controller_clamped_unit and the testbench.
package pidc_pkg;

  // Width of the configuration register index
  localparam int CFG_INDEX_W = 3;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_KP_GAIN        = 3'd0,
    REG_KI_GAIN        = 3'd1,
    REG_KD_GAIN        = 3'd2,
    REG_INTEG_LOW      = 3'd3,
    REG_INTEG_HIGH     = 3'd4,
    REG_DRIVE_LOW      = 3'd5,
    REG_DRIVE_HIGH     = 3'd6
  } cfg_reg_t;

endpackage

// ----- design/pid_controller_clamped_unit.sv -----
// pid_controller_clamped_unit: discrete PID step in signed fixed point with an
// integral clamp and an output clamp, four-stage registered pipeline.
// Depends on pidc_pkg (configuration register indexes).
//
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  input    | in_valid, in_ready, target_value,         | in
//           | measured_value                            |
//  output   | out_valid, out_ready, drive               | out
//  config   | cfg_write, cfg_index, cfg_data            | in
//
// One word is accepted per cycle while in_ready is high; its drive word passes
// through the stage 1, 2, 3 and 4 registers before out_valid rises.
// Stage 1 forms the error and updates the integral and the
// previous error (one add and clamp per accepted word), stage 2 holds the three
// gain multiplies, stage 3 rounds and saturates, stage 4 sums and clamps.
// Each stage has its own valid bit and moves when the next stage is empty or
// moving, so bubbles collapse under an output stall.
// Synchronous reset clears the valid bits and the state, zeroes the gains and sets the limits to the full word range.
module pid_controller_clamped_unit #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [DATA_WIDTH-1:0]        target_value,
  input  logic signed [DATA_WIDTH-1:0]        measured_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [DATA_WIDTH-1:0]        drive,
  input  logic                                cfg_write,
  input  logic [pidc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [DATA_WIDTH-1:0]               cfg_data
);
  import pidc_pkg::*;

  localparam int DW  = DATA_WIDTH;
  localparam int PDW = 2 * DATA_WIDTH + 1;   // widest product (derivative)

  localparam logic signed [DW-1:0] WMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] WMIN = {1'b1, {(DW-1){1'b0}}};
  localparam logic signed [PDW-1:0] WMAX_P = {{(PDW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [PDW-1:0] WMIN_P = ~WMAX_P;
  localparam logic signed [PDW-1:0] RBIAS  = {{(PDW-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};

  // Product shifted right toward zero, then saturated to the word width
  function automatic logic signed [DW-1:0] round_sat(input logic signed [PDW-1:0] x);
    logic signed [PDW-1:0] biased;
    logic signed [PDW-1:0] q;
    biased = x + (x[PDW-1] ? RBIAS : '0);
    q      = biased >>> FRAC_BITS;
    priority if (q > WMAX_P) begin
      return WMAX;
    end else if (q < WMIN_P) begin
      return WMIN;
    end else begin
      return q[DW-1:0];
    end
  endfunction

  // Configuration registers
  logic signed [DW-1:0] kp_gain, ki_gain, kd_gain;
  logic signed [DW-1:0] integ_low, integ_high, drive_low, drive_high;

  always_ff @(posedge clk) begin
    if (rst) begin
      kp_gain    <= '0;
      ki_gain    <= '0;
      kd_gain    <= '0;
      integ_low  <= WMIN;
      integ_high <= WMAX;
      drive_low  <= WMIN;
      drive_high <= WMAX;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_KP_GAIN:    kp_gain    <= cfg_data;
        REG_KI_GAIN:    ki_gain    <= cfg_data;
        REG_KD_GAIN:    kd_gain    <= cfg_data;
        REG_INTEG_LOW:  integ_low  <= cfg_data;
        REG_INTEG_HIGH: integ_high <= cfg_data;
        REG_DRIVE_LOW:  drive_low  <= cfg_data;
        REG_DRIVE_HIGH: drive_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage handshake: a stage loads when it is empty or the next one moves
  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4;
  logic in_acc;

  assign rdy4     = !v4 || out_ready;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;
  assign in_acc   = in_valid && rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  // Stage 1 logic: saturated error, clamped integral, derivative difference
  logic signed [DW:0]   err_wide;
  logic signed [DW-1:0] err_sat;
  logic signed [DW:0]   integ_wide;
  logic signed [DW-1:0] integral_next;
  logic signed [DW:0]   diff_next;
  logic signed [DW-1:0] integral_sum, previous_error;

  always_comb begin
    err_wide = {target_value[DW-1], target_value} - {measured_value[DW-1], measured_value};
    priority if (err_wide[DW] != err_wide[DW-1]) begin
      err_sat = err_wide[DW] ? WMIN : WMAX;
    end else begin
      err_sat = err_wide[DW-1:0];
    end

    integ_wide = {integral_sum[DW-1], integral_sum} + {err_sat[DW-1], err_sat};
    priority if (integ_wide > $signed({integ_high[DW-1], integ_high})) begin
      integral_next = integ_high;
    end else if (integ_wide < $signed({integ_low[DW-1], integ_low})) begin
      integral_next = integ_low;
    end else begin
      integral_next = integ_wide[DW-1:0];
    end

    diff_next = {err_sat[DW-1], err_sat} - {previous_error[DW-1], previous_error};
  end

  // Controller state, updated once per accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      integral_sum   <= '0;
      previous_error <= '0;
    end else if (in_acc) begin
      integral_sum   <= integral_next;
      previous_error <= err_sat;
    end
  end

  logic signed [DW-1:0] s1_err, s1_integ;
  logic signed [DW:0]   s1_diff;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_err   <= err_sat;
      s1_integ <= integral_next;
      s1_diff  <= diff_next;
    end
  end

  // Stage 2: the three gain products at full precision
  logic signed [2*DW-1:0] prod_p, prod_i;
  logic signed [PDW-1:0]  prod_d;
  logic signed [PDW-1:0]  s2_p, s2_i, s2_d;

  assign prod_p = kp_gain * s1_err;
  assign prod_i = ki_gain * s1_integ;
  assign prod_d = kd_gain * s1_diff;

  always_ff @(posedge clk) begin
    if (v1 && rdy2) begin
      s2_p <= {prod_p[2*DW-1], prod_p};
      s2_i <= {prod_i[2*DW-1], prod_i};
      s2_d <= prod_d;
    end
  end

  // Stage 3: round toward zero and saturate each term
  logic signed [DW-1:0] s3_p, s3_i, s3_d;

  always_ff @(posedge clk) begin
    if (v2 && rdy3) begin
      s3_p <= round_sat(s2_p);
      s3_i <= round_sat(s2_i);
      s3_d <= round_sat(s2_d);
    end
  end

  // Stage 4: exact sum and output clamp, high limit tested first
  logic signed [DW+1:0] total;
  logic signed [DW-1:0] drive_next;

  always_comb begin
    total = {{2{s3_p[DW-1]}}, s3_p} + {{2{s3_i[DW-1]}}, s3_i} + {{2{s3_d[DW-1]}}, s3_d};
    priority if (total > $signed({{2{drive_high[DW-1]}}, drive_high})) begin
      drive_next = drive_high;
    end else if (total < $signed({{2{drive_low[DW-1]}}, drive_low})) begin
      drive_next = drive_low;
    end else begin
      drive_next = total[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (v3 && rdy4) begin
      drive <= drive_next;
    end
  end

  assign out_valid = v4;

`ifndef SYNTHESIS
  // Integral lands inside ordered limits after every accepted word
  a_integ_in_limits: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $past(in_acc) && $past(integ_low) <= $past(integ_high)) |->
      (integral_sum >= $past(integ_low) && integral_sum <= $past(integ_high)))
    else $error("integral outside its limits");

  // Stored previous error matches the error handed to stage 1
  a_prev_err: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $past(in_acc)) |-> (previous_error == s1_err))
    else $error("previous error out of step with stage 1");

  // A free slot at the end of the pipeline never blocks the input
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !v4 |-> in_ready)
    else $error("input blocked with empty output stage");

  // A stalled stage 1 keeps its word
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (v1 && !rdy2) |=> (v1 && $stable(s1_err) && $stable(s1_diff)))
    else $error("stage 1 word lost under stall");
`endif

endmodule

// ----- sim/testbench.sv -----
// testbench: self-checking bench for pid_controller_clamped_unit, directed
// cases and then random traffic compared word by word against a local PID model.
// Depends on pidc_pkg and design/pid_controller_clamped_unit.sv.
module testbench;
  import pidc_pkg::*;

  localparam int DW = 32;
  localparam int FB = 16;
  localparam int PIPE_DEPTH = 4;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_PHASES = 16;
  localparam int PHASE_ITEMS = 100;

  localparam logic signed [DW-1:0] WORD_MAX = 32'sh7fffffff;
  localparam logic signed [DW-1:0] WORD_MIN = 32'sh80000000;
  localparam logic signed [DW-1:0] ONE_Q    = 32'sh00010000;
  // index 7 has no register behind it
  localparam logic [CFG_INDEX_W-1:0] UNUSED_INDEX = 3'd7;

  typedef logic signed [79:0] wide_t;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic signed [DW-1:0] target_value;
  logic signed [DW-1:0] measured_value;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [DW-1:0] drive;
  logic cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [DW-1:0] cfg_data;

  pid_controller_clamped_unit #(
    .DATA_WIDTH(DW),
    .FRAC_BITS (FB)
  ) uut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .target_value  (target_value),
    .measured_value(measured_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .drive         (drive),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Controller model: settings and loop state
  logic signed [DW-1:0] gain_p = '0, gain_i = '0, gain_d = '0;
  logic signed [DW-1:0] integ_lo = WORD_MIN, integ_hi = WORD_MAX;
  logic signed [DW-1:0] drive_lo = WORD_MIN, drive_hi = WORD_MAX;
  logic signed [DW-1:0] integ_acc = '0, prev_err = '0;

  logic signed [DW-1:0] expected_drive[$];
  logic signed [DW-1:0] want_drive;

  int errors = 0;
  int words_sent = 0;
  int words_checked = 0;
  int settings_loaded = 0;
  int input_stall_cycles = 0;
  int long_holds = 0;

  // receiver stall control
  bit hold_req = 1'b0;
  int hold_len = 0;
  int hold_left = 0;
  int stall_pct = 0;
  int stall_run = 0;

  function automatic logic signed [DW-1:0] sat_word(input wide_t v);
    wide_t hi, lo;
    hi = WORD_MAX;
    lo = WORD_MIN;
    if (v > hi) return WORD_MAX;
    if (v < lo) return WORD_MIN;
    return v[DW-1:0];
  endfunction

  // upper limit is tested first, so inverted limits give the high one above it, else the low one
  function automatic wide_t clamp_hi_first(input wide_t v, input wide_t lo, input wide_t hi);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // full-precision product, magnitude shifted (round toward zero), saturated
  function automatic wide_t fixed_mul(input wide_t a, input wide_t b);
    wide_t prod, q;
    prod = a * b;
    q = (prod < 0) ? -prod : prod;
    q = q >> FB;
    if (prod < 0) q = -q;
    return sat_word(q);
  endfunction

  // One PID step; updates the integral and previous error
  function automatic logic signed [DW-1:0] pid_predict(input logic signed [DW-1:0] tgt,
                                                       input logic signed [DW-1:0] meas);
    wide_t t, m, err, sum, p_term, i_term, d_term, total;
    t = tgt;
    m = meas;
    err = sat_word(t - m);
    sum = clamp_hi_first(integ_acc + err, integ_lo, integ_hi);
    integ_acc = sum[DW-1:0];
    p_term = fixed_mul(gain_p, err);
    i_term = fixed_mul(gain_i, sum);
    // difference kept one bit wider, not saturated
    d_term = fixed_mul(gain_d, err - prev_err);
    prev_err = err[DW-1:0];
    total = clamp_hi_first(p_term + i_term + d_term, drive_lo, drive_hi);
    return total[DW-1:0];
  endfunction

  // Result checker: each drive word against the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_drive.size() == 0) begin
        $display("%0t: unexpected drive word: expected none, actual %0d (0x%h)",
                 $time, drive, drive);
        errors++;
      end else begin
        want_drive = expected_drive.pop_front();
        if (drive !== want_drive) begin
          $display("%0t: drive mismatch: expected %0d (0x%h), actual %0d (0x%h)",
                   $time, want_drive, want_drive, drive, drive);
          errors++;
        end
      end
      words_checked++;
    end
  end

  // Receiver: long hold-off on request, otherwise phases of random stalls
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = hold_len;
      hold_req = 1'b0;
      long_holds++;
    end
    if (hold_left > 0) begin
      out_ready = 1'b0;
      hold_left--;
    end else begin
      if (stall_run == 0) begin
        case ($urandom_range(0, 4))
          0, 1: stall_pct = 0;
          2: stall_pct = 30;
          3: stall_pct = 60;
          default: stall_pct = 90;
        endcase
        stall_run = $urandom_range(16, 96);
      end
      stall_run--;
      out_ready = ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Watchdog
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("%0t: timeout after %0d cycles, %0d words still expected",
             $time, cycles, expected_drive.size());
    $display("Test completed with failures");
    $finish;
  end

  // Register write; model follows only for known indexes
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic signed [DW-1:0] val);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_write = 1'b0;
    case (idx)
      REG_KP_GAIN:    gain_p   = val;
      REG_KI_GAIN:    gain_i   = val;
      REG_KD_GAIN:    gain_d   = val;
      REG_INTEG_LOW:  integ_lo = val;
      REG_INTEG_HIGH: integ_hi = val;
      REG_DRIVE_LOW:  drive_lo = val;
      REG_DRIVE_HIGH: drive_hi = val;
      default: ;
    endcase
  endtask

  // Offer one word and hold it until accepted
  task automatic send_word(input logic signed [DW-1:0] tgt, input logic signed [DW-1:0] meas);
    @(negedge clk);
    in_valid = 1'b1;
    target_value = tgt;
    measured_value = meas;
    @(posedge clk);
    while (!in_ready) begin
      input_stall_cycles++;
      @(posedge clk);
    end
    expected_drive.push_back(pid_predict(tgt, meas));
    words_sent++;
  endtask

  // Drop valid and wait for the pipeline to drain
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_drive.size() != 0) @(negedge clk);
    repeat (PIPE_DEPTH) @(negedge clk);
  endtask

  function automatic logic signed [DW-1:0] rand_sample();
    int span, r;
    case ($urandom_range(0, 5))
      0, 1: return $urandom;
      2: begin
        case ($urandom_range(0, 4))
          0: return WORD_MAX;
          1: return WORD_MIN;
          2: return '0;
          3: return -1;
          default: return 1;
        endcase
      end
      default: begin
        // small values, up to about +/-16.0
        span = $urandom_range(1, 'h100000);
        r = $urandom_range(0, 2 * span);
        return r - span;
      end
    endcase
  endfunction

  function automatic logic signed [DW-1:0] rand_gain();
    int r;
    case ($urandom_range(0, 6))
      0: return '0;
      1, 2: begin
        r = $urandom_range(0, 'h80000);
        return r - 'h40000;
      end
      3: begin
        r = $urandom_range(0, 'h20000);
        return r - 'h10000;
      end
      4: return WORD_MAX;
      5: return WORD_MIN;
      default: return $urandom;
    endcase
  endfunction

  task automatic rand_limits(output logic signed [DW-1:0] lo, output logic signed [DW-1:0] hi);
    logic signed [DW-1:0] a, b;
    int span;
    a = rand_sample();
    b = rand_sample();
    case ($urandom_range(0, 5))
      0: begin
        lo = WORD_MIN;
        hi = WORD_MAX;
      end
      1, 2: begin
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
      end
      3: begin
        span = $urandom_range(0, 'h200000);
        lo = -span;
        hi = span;
      end
      4: begin
        // inverted pair
        lo = (a < b) ? b : a;
        hi = (a < b) ? a : b;
      end
      default: begin
        lo = a;
        hi = a;
      end
    endcase
  endtask

  task automatic load_random_settings();
    logic signed [DW-1:0] lo, hi;
    write_reg(REG_KP_GAIN, rand_gain());
    write_reg(REG_KI_GAIN, rand_gain());
    write_reg(REG_KD_GAIN, rand_gain());
    rand_limits(lo, hi);
    write_reg(REG_INTEG_LOW, lo);
    write_reg(REG_INTEG_HIGH, hi);
    rand_limits(lo, hi);
    write_reg(REG_DRIVE_LOW, lo);
    write_reg(REG_DRIVE_HIGH, hi);
    if ($urandom_range(0, 3) == 0) write_reg(UNUSED_INDEX, $urandom);
    settings_loaded++;
  endtask

  // Mostly a measurement tracking a setpoint, the rest arbitrary words
  task automatic run_stream(input int count, input bit bursty);
    logic signed [DW-1:0] setpoint, tgt, meas;
    int k, burst_left, gap, noise;
    setpoint = rand_sample();
    burst_left = $urandom_range(1, 24);
    for (k = 0; k < count; k++) begin
      if ($urandom_range(0, 9) < 7) begin
        if ($urandom_range(0, 31) == 0) setpoint = rand_sample();
        noise = $urandom_range(0, 'h10000);
        tgt = setpoint;
        meas = setpoint + noise - 'h8000;
      end else begin
        tgt = rand_sample();
        meas = rand_sample();
      end
      send_word(tgt, meas);
      if (bursty) begin
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap = $urandom_range(1, 10);
          @(negedge clk);
          in_valid = 1'b0;
          repeat (gap - 1) @(negedge clk);
        end
      end
    end
  endtask

  // Reset values: zero gains, so drive is zero while the integral moves
  task automatic test_default_config();
    send_word(WORD_MAX, WORD_MIN);
    send_word(WORD_MIN, WORD_MAX);
    send_word('0, '0);
    wait_idle();
  endtask

  // Error saturation, product saturation, derivative span, rounding to zero
  task automatic test_error_saturation();
    write_reg(REG_KP_GAIN, ONE_Q);
    send_word(WORD_MAX, WORD_MIN);
    send_word(WORD_MIN, WORD_MAX);
    send_word(32'sh12345678, 32'sh00001234);
    wait_idle();
    write_reg(REG_KP_GAIN, '0);
    write_reg(REG_KD_GAIN, WORD_MAX);
    send_word(WORD_MAX, WORD_MIN);
    send_word(WORD_MIN, WORD_MAX);
    wait_idle();
    write_reg(REG_KD_GAIN, '0);
    write_reg(REG_KP_GAIN, WORD_MIN);
    send_word(WORD_MIN, '0);
    wait_idle();
    // smallest gain: sub-LSB products round toward zero
    write_reg(REG_KP_GAIN, 32'sh00000001);
    send_word('0, 1);
    send_word(32'sh0001ffff, '0);
    wait_idle();
  endtask

  // Integral and drive clamps, including inverted limits
  task automatic test_clamps();
    write_reg(REG_KP_GAIN, '0);
    write_reg(REG_KI_GAIN, ONE_Q);
    write_reg(REG_INTEG_LOW, -32'sh30000);
    write_reg(REG_INTEG_HIGH, 32'sh20000);
    repeat (3) send_word(32'sh10000, '0);
    send_word('0, 32'sh100000);
    wait_idle();
    write_reg(REG_INTEG_LOW, 32'sh10000);
    write_reg(REG_INTEG_HIGH, -32'sh10000);
    send_word(32'sh40000, '0);
    send_word('0, 32'sh40000);
    wait_idle();
    write_reg(REG_INTEG_LOW, WORD_MIN);
    write_reg(REG_INTEG_HIGH, WORD_MAX);
    write_reg(REG_KI_GAIN, '0);
    write_reg(REG_KP_GAIN, ONE_Q);
    write_reg(REG_DRIVE_LOW, -32'sh8000);
    write_reg(REG_DRIVE_HIGH, 32'sh8000);
    send_word(32'sh20000, '0);
    send_word('0, 32'sh20000);
    wait_idle();
    write_reg(REG_DRIVE_LOW, 32'sh8000);
    write_reg(REG_DRIVE_HIGH, -32'sh8000);
    send_word(32'sh20000, '0);
    send_word('0, 32'sh100);
    wait_idle();
  endtask

  // A write to the unused index must leave every register alone
  task automatic test_unused_index();
    write_reg(REG_DRIVE_LOW, WORD_MIN);
    write_reg(REG_DRIVE_HIGH, WORD_MAX);
    write_reg(UNUSED_INDEX, 32'hffffffff);
    send_word(32'sh30000, '0);
    send_word('0, 32'sh30000);
    wait_idle();
  endtask

  // Output held off for a long stretch while words keep coming
  task automatic test_backpressure();
    write_reg(REG_KP_GAIN, ONE_Q);
    write_reg(REG_KI_GAIN, 32'sh00001000);
    write_reg(REG_KD_GAIN, -ONE_Q);
    hold_len = 80;
    hold_req = 1'b1;
    repeat (40) send_word(rand_sample(), rand_sample());
    wait_idle();
  endtask

  task automatic test_random_traffic();
    int ph;
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      load_random_settings();
      run_stream(PHASE_ITEMS, $urandom_range(0, 3) != 0);
      wait_idle();
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    target_value = '0;
    measured_value = '0;
    cfg_write = 1'b0;
    cfg_index = REG_KP_GAIN;
    cfg_data = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_default_config();
    test_error_saturation();
    test_clamps();
    test_unused_index();
    test_backpressure();
    test_random_traffic();

    wait_idle();
    repeat (2 * PIPE_DEPTH) @(posedge clk);
    $display("Ran %0d PID steps (%0d drive words checked) over %0d random settings",
             words_sent, words_checked, settings_loaded);
    $display("plus directed clamp cases; input stalled %0d cycles, %0d long output holds",
             input_stall_cycles, long_holds);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
